FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the exchange sort RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define DESX_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define DESX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Check that cons holds in the same cycle as ante.
`define DESX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DESX_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define DESX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define DESX_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/desx_pkg.sv
// Types, constants and microcode table of the descending exchange sort.
`timescale 1ns / 1ps
`default_nettype none
package desx_pkg;

   localparam int DEF_MAX_ENTRIES = 32;
   localparam int SCORE_W = 16;
   localparam int TAG_W   = 16;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   typedef enum logic [2:0] {
      STEP_IDLE     = 3'd0,
      STEP_INIT     = 3'd1,
      STEP_OUTER    = 3'd2,
      STEP_LOAD_CUR = 3'd3,
      STEP_CMP      = 3'd4,
      STEP_WB       = 3'd5,
      STEP_EMIT0    = 3'd6,
      STEP_EMIT     = 3'd7
   } step_type;

   typedef enum logic [2:0] {
      ACT_IDLE      = 3'd0,
      ACT_INIT_I    = 3'd1,
      ACT_OUTER     = 3'd2,
      ACT_LOAD_CUR  = 3'd3,
      ACT_CMP       = 3'd4,
      ACT_WB        = 3'd5,
      ACT_EMIT_INIT = 3'd6,
      ACT_EMIT      = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      COND_ALWAYS       = 3'd0,
      COND_ACCEPT_FINAL = 3'd1,
      COND_I_DONE       = 3'd2,
      COND_J_LAST       = 3'd3,
      COND_K_LAST       = 3'd4
   } cond_type;

   typedef struct packed {
      action_type action;
      cond_type   cond;
      step_type   jump_step;
      step_type   fall_step;
   } ctl_word_type;

   // Control store: take jump_step when cond holds, else fall_step.
   function automatic ctl_word_type ucode_rom(input step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_IDLE:     w = '{ACT_IDLE,      COND_ACCEPT_FINAL, STEP_INIT,     STEP_IDLE};
         STEP_INIT:     w = '{ACT_INIT_I,    COND_ALWAYS,       STEP_OUTER,    STEP_OUTER};
         STEP_OUTER:    w = '{ACT_OUTER,     COND_I_DONE,       STEP_EMIT0,    STEP_LOAD_CUR};
         STEP_LOAD_CUR: w = '{ACT_LOAD_CUR,  COND_ALWAYS,       STEP_CMP,      STEP_CMP};
         STEP_CMP:      w = '{ACT_CMP,       COND_J_LAST,       STEP_WB,       STEP_CMP};
         STEP_WB:       w = '{ACT_WB,        COND_ALWAYS,       STEP_OUTER,    STEP_OUTER};
         STEP_EMIT0:    w = '{ACT_EMIT_INIT, COND_ALWAYS,       STEP_EMIT,     STEP_EMIT};
         STEP_EMIT:     w = '{ACT_EMIT,      COND_K_LAST,       STEP_IDLE,     STEP_EMIT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/desx_store.sv
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module desx_store #(
   parameter int DEPTH = desx_pkg::DEF_MAX_ENTRIES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire desx_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output desx_pkg::entry_type      rd_data
);
   import desx_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/descending_exchange_sort_core.sv
// Top level of the descending exchange sort: microcoded sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------------
//  request   start & !busy           req_score, req_name_tag, req_final_item
//  response  rsp_valid (one cycle)   rsp_sorted_score, rsp_sorted_tag, rsp_end_of_run
//
//  A non-final request beat leaves busy low, so loads stream back to back.
//  A final beat starts the sort; the block stays busy through the compare loop, which
//  runs one compare per cycle, bounded by the single read and single write port of the
//  entry store, and through the response beats, one per cycle. Reset (synchronous)
//  empties the set and returns to idle; store contents are not cleared. The receiver
//  cannot stall, so responses never wait.
//
module descending_exchange_sort_core #(
   parameter int MAX_ENTRIES = desx_pkg::DEF_MAX_ENTRIES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [desx_pkg::SCORE_W-1:0] req_score,
   input  wire logic [desx_pkg::TAG_W-1:0]          req_name_tag,
   input  wire logic                                req_final_item,
   output logic                                     rsp_valid,
   output logic signed [desx_pkg::SCORE_W-1:0]      rsp_sorted_score,
   output logic [desx_pkg::TAG_W-1:0]               rsp_sorted_tag,
   output logic                                     rsp_end_of_run
);
   import desx_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] ONE = CW'(1);

   // Sequencer state and loop counters.
   step_type     step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   entry_type     cur_ff, cur_in;

   ctl_word_type  ctl;
   logic          accept;
   logic          hit;
   logic [CW-1:0] i_inc, j_inc, k_inc;

   // Store port controls.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   entry_type     req_entry;

   assign i_inc = i_ff + ONE;
   assign j_inc = j_ff + ONE;
   assign k_inc = k_ff + ONE;
   assign req_entry = '{score: req_score, tag: req_name_tag};

   // Fetch the control word of the current step.
   always_comb begin
      ctl = ucode_rom(step_ff);
   end

   assign busy   = (ctl.action != ACT_IDLE);
   assign accept = start && !busy;

   // Next step: evaluate the jump condition of the current word.
   always_comb begin
      unique case (ctl.cond)
         COND_ALWAYS:       hit = 1'b1;
         COND_ACCEPT_FINAL: hit = accept && req_final_item;
         COND_I_DONE:       hit = (i_inc >= count_ff);
         COND_J_LAST:       hit = (j_inc >= count_ff);
         COND_K_LAST:       hit = (k_inc >= count_ff);
         default:           hit = 1'b0;
      endcase
      step_in = hit ? ctl.jump_step : ctl.fall_step;
   end

   // Datapath decode: one action per control word.
   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = req_entry;
      rd_addr  = '0;
      unique case (ctl.action)
         ACT_IDLE: begin
            // Store the beat while there is room; drop it when full.
            if (accept && (count_ff < MAX_COUNT)) begin
               wr_en    = 1'b1;
               count_in = count_ff + ONE;
            end
         end
         ACT_INIT_I: begin
            i_in = '0;
         end
         ACT_OUTER: begin
            rd_addr = i_ff[AW-1:0];
            j_in    = i_inc;
         end
         ACT_LOAD_CUR: begin
            cur_in  = rd_data;
            rd_addr = j_ff[AW-1:0];
         end
         ACT_CMP: begin
            // Entry i lives in cur; swap with entry j when it scores lower.
            if (cur_ff.score < rd_data.score) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            rd_addr = j_inc[AW-1:0];
            j_in    = j_inc;
         end
         ACT_WB: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[AW-1:0];
            wr_data = cur_ff;
            i_in    = i_inc;
         end
         ACT_EMIT_INIT: begin
            k_in    = '0;
            rd_addr = '0;
         end
         ACT_EMIT: begin
            rd_addr = k_inc[AW-1:0];
            k_in    = k_inc;
            if (k_inc >= count_ff) begin
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   desx_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response beat: the registered read of entry k.
   assign rsp_valid        = (ctl.action == ACT_EMIT);
   assign rsp_sorted_score = rd_data.score;
   assign rsp_sorted_tag   = rd_data.tag;
   assign rsp_end_of_run   = rsp_valid && (k_inc >= count_ff);

   `DESX_ASSERT_ALWAYS(a_count_cap, clock, reset, count_ff <= MAX_COUNT, "entry count over capacity")
   `DESX_ASSERT_SAME(a_cmp_in_set, clock, reset, ctl.action == ACT_CMP, j_ff < count_ff, "compare index outside set")
   `DESX_ASSERT_NEXT(a_final_busy, clock, reset, accept && req_final_item, busy, "final beat did not start the sort")
   `DESX_ASSERT_NEXT(a_end_idle, clock, reset, rsp_valid && rsp_end_of_run, !busy && (count_ff == '0), "run did not close after last beat")
   `DESX_ASSERT_SAME(a_emit_nonempty, clock, reset, rsp_valid, count_ff != '0, "response beat from an empty set")

endmodule
`default_nettype wire

FILE: bench/descending_exchange_sort_core_test.sv
// Self-checking testbench for the descending exchange sort core.
`timescale 1ns / 1ps

module descending_exchange_sort_core_test;

   localparam int CAPACITY = desx_pkg::DEF_MAX_ENTRIES;
   localparam int SW = desx_pkg::SCORE_W;
   localparam int TW = desx_pkg::TAG_W;
   // Allow several times the sort of a full set with no beat moving.
   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PRINT_CAP = 200;

   // One load beat as the driver presents it.
   typedef struct packed {
      logic signed [SW-1:0] score;
      logic [TW-1:0]        tag;
      logic                 final_item;
   } load_beat_type;

   // One ranked result as the core should emit it.
   typedef struct packed {
      logic signed [SW-1:0] score;
      logic [TW-1:0]        tag;
      logic                 last;
   } ranked_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic signed [SW-1:0] req_score = '0;
   logic [TW-1:0]        req_name_tag = '0;
   logic                 req_final_item = 1'b0;
   wire                  busy;
   wire                  rsp_valid;
   wire signed [SW-1:0]  rsp_sorted_score;
   wire [TW-1:0]         rsp_sorted_tag;
   wire                  rsp_end_of_run;

   descending_exchange_sort_core #(
      .MAX_ENTRIES(CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_score(req_score),
      .req_name_tag(req_name_tag),
      .req_final_item(req_final_item),
      .rsp_valid(rsp_valid),
      .rsp_sorted_score(rsp_sorted_score),
      .rsp_sorted_tag(rsp_sorted_tag),
      .rsp_end_of_run(rsp_end_of_run)
   );

   // Beats waiting for the driver, and the ranking we expect back, oldest first.
   load_beat_type pending_loads[$];
   ranked_type    expected_ranking[$];

   // Private copy of the core's entry store.
   logic signed [SW-1:0] bank_score [CAPACITY];
   logic [TW-1:0]        bank_tag [CAPACITY];
   int                   bank_count = 0;

   int sender_idle_pct = 0;
   int loads_queued = 0;
   int loads_taken = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Store one accepted beat; on a final beat sort the set and queue its ranking.
   task automatic absorb_load(input logic signed [SW-1:0] s, input logic [TW-1:0] t,
                              input logic fin);
      int                   a;
      int                   b;
      logic signed [SW-1:0] hold_s;
      logic [TW-1:0]        hold_t;
      ranked_type           r;
      // Drop the pair once the store is full; a dropped final beat still closes the set.
      if (bank_count < CAPACITY) begin
         bank_score[bank_count] = s;
         bank_tag[bank_count] = t;
         bank_count++;
      end
      if (fin) begin
         // Swap i and j only on a strict signed less-than, so ties keep loop order.
         for (a = 0; a < bank_count; a++) begin
            for (b = a + 1; b < bank_count; b++) begin
               if (bank_score[a] < bank_score[b]) begin
                  hold_s = bank_score[a];
                  hold_t = bank_tag[a];
                  bank_score[a] = bank_score[b];
                  bank_tag[a] = bank_tag[b];
                  bank_score[b] = hold_s;
                  bank_tag[b] = hold_t;
               end
            end
         end
         for (a = 0; a < bank_count; a++) begin
            r.score = bank_score[a];
            r.tag = bank_tag[a];
            r.last = (a == bank_count - 1);
            expected_ranking.push_back(r);
         end
         bank_count = 0;
      end
   endtask

   task automatic queue_load(input logic signed [SW-1:0] s, input logic [TW-1:0] t,
                             input logic fin);
      load_beat_type lb;
      lb.score = s;
      lb.tag = t;
      lb.final_item = fin;
      pending_loads.push_back(lb);
      loads_queued++;
   endtask

   // Driver: a beat moves on a rising edge with start high and busy low.
   // Hold the beat while busy; once it moves, present the next one or idle.
   always @(posedge clock) begin : load_driver
      load_beat_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_load(req_score, req_name_tag, req_final_item);
            loads_taken++;
         end
         if (!start || !busy) begin
            if (pending_loads.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_loads.pop_front();
               req_score <= nxt.score;
               req_name_tag <= nxt.tag;
               req_final_item <= nxt.final_item;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed result is compared with the oldest expected entry.
   always @(posedge clock) begin : ranking_monitor
      ranked_type want;
      if (!reset && rsp_valid) begin
         if (expected_ranking.size() == 0) begin
            report_mismatch($sformatf("unexpected result score=%0d tag=%h last=%b",
                                      rsp_sorted_score, rsp_sorted_tag, rsp_end_of_run));
         end else begin
            want = expected_ranking.pop_front();
            if (rsp_sorted_score !== want.score)
               report_mismatch($sformatf("sorted_score %0d, expected %0d",
                                         rsp_sorted_score, want.score));
            if (rsp_sorted_tag !== want.tag)
               report_mismatch($sformatf("sorted_tag %h, expected %h",
                                         rsp_sorted_tag, want.tag));
            if (rsp_end_of_run !== want.last)
               report_mismatch($sformatf("end_of_run %b, expected %b",
                                         rsp_end_of_run, want.last));
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                   idle_plan [4];
      int                   phase;
      int                   budget;
      int                   set_len;
      int                   key_mode;
      int                   k;
      int                   pick;
      logic signed [SW-1:0] s;

      idle_plan = '{0, 55, 0, 11};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: a lone final beat at the most negative score.
      queue_load(16'sh8000, 16'h0000, 1'b1);
      // Extremes of both fields, zero, minus one, and a three-way tie on score.
      queue_load(16'sh0005, 16'h00A1, 1'b0);
      queue_load(16'sh7FFF, 16'hFFFF, 1'b0);
      queue_load(16'sh8000, 16'h0000, 1'b0);
      queue_load(16'sh0005, 16'h00B2, 1'b0);
      queue_load(16'sh0000, 16'h5555, 1'b0);
      queue_load(16'shFFFF, 16'hAAAA, 1'b0);
      queue_load(16'sh0001, 16'h0001, 1'b0);
      queue_load(16'sh0005, 16'h00C3, 1'b1);
      // All scores equal: no swap may happen.
      queue_load(16'sh0003, 16'h1111, 1'b0);
      queue_load(16'sh0003, 16'h2222, 1'b0);
      queue_load(16'sh0003, 16'h3333, 1'b1);
      // Strictly ascending input: worst case for swaps.
      queue_load(16'sh8001, 16'h0010, 1'b0);
      queue_load(-16'sd2, 16'h0020, 1'b0);
      queue_load(16'sh0002, 16'h0030, 1'b0);
      queue_load(16'sh7FFE, 16'h0040, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         budget = 105;
         while (budget > 0) begin
            // Mostly short sets; some below capacity, and some that fill or overflow it.
            pick = $urandom_range(99);
            if (pick < 65)
               set_len = $urandom_range(1, 6);
            else if (pick < 85)
               set_len = $urandom_range(7, CAPACITY - 1);
            else
               set_len = $urandom_range(CAPACITY, CAPACITY + 4);
            key_mode = $urandom_range(3);
            for (k = 0; k < set_len; k++) begin
               case (key_mode)
                  0: s = SW'($urandom);
                  1: begin
                     // Dense ties around zero.
                     s = SW'($urandom_range(0, 6));
                     s = s - 16'sd3;
                  end
                  2: begin
                     case ($urandom_range(3))
                        0: s = 16'sh8000;
                        1: s = 16'sh7FFF;
                        2: s = 16'sh0000;
                        default: s = 16'shFFFF;
                     endcase
                  end
                  default: begin
                     s = SW'($urandom_range(0, 511));
                     s = s - 16'sd256;
                  end
               endcase
               queue_load(s, TW'($urandom), k == set_len - 1);
            end
            budget -= set_len;
         end
         // Drain this phase before changing the idle pattern.
         while (loads_taken != loads_queued) @(posedge clock);
      end

      while (expected_ranking.size() != 0) @(posedge clock);
      // Linger to catch any stray result after the last run.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
